[src/usbep0_pkg.sv]
// Shared types, codes and descriptor tables of the USB endpoint-zero responder.
// No dependencies; used by the microcode ROM, the sequencer and the top level.
package usbep0_pkg;

    // Interrupt status codes from the interface chip
    localparam logic [7:0] STS_SETUP = 8'h0C;
    localparam logic [7:0] STS_EP0_IN = 8'h08;
    localparam logic [7:0] STS_EP0_OUT = 8'h00;

    // Standard requests and descriptor types
    localparam logic [7:0] REQ_GET_DESC = 8'h06;
    localparam logic [7:0] REQ_SET_ADDR = 8'h05;
    localparam logic [7:0] SETUP_LEN = 8'h08;
    localparam logic [1:0] DESC_NONE = 2'd0;
    localparam logic [1:0] DESC_DEVICE = 2'd1;
    localparam logic [1:0] DESC_CONFIG = 2'd2;
    localparam logic [4:0] DEVICE_SIZE = 5'd18;
    localparam logic [4:0] CONFIG_SIZE = 5'd9;
    localparam logic [4:0] NULL_SIZE = 5'd8;

    // Chip command bytes
    localparam logic [7:0] CMD_WR_EP0 = 8'h29;
    localparam logic [7:0] CMD_UNLOCK = 8'h23;
    localparam logic [7:0] CMD_SET_ADDR = 8'h13;

    // Action codes on the result channel
    localparam logic [1:0] ACT_CMD = 2'd0;
    localparam logic [1:0] ACT_DATA = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_VENDOR_ID = 2'd0;
    localparam logic [1:0] CFG_PRODUCT_ID = 2'd1;
    localparam logic [1:0] CFG_MAX_POWER = 2'd2;

    // Microcode: byte sources and end conditions
    localparam logic [1:0] SRC_IMM = 2'd0;
    localparam logic [1:0] SRC_LEN = 2'd1;
    localparam logic [1:0] SRC_DESC = 2'd2;
    localparam logic [1:0] SRC_ADDR = 2'd3;
    localparam logic [1:0] END_NEVER = 2'd0;
    localparam logic [1:0] END_ALWAYS = 2'd1;
    localparam logic [1:0] END_IF_LEN0 = 2'd2;

    // Program entry points in the microcode ROM
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_GET_DESC = 5'd0;
    localparam logic [PC_W-1:0] PC_IN_DESC = 5'd4;
    localparam logic [PC_W-1:0] PC_SET_ADDR = 5'd8;
    localparam logic [PC_W-1:0] PC_IN_ADDR = 5'd11;
    localparam logic [PC_W-1:0] PC_UNLOCK = 5'd14;
    localparam logic [PC_W-1:0] PC_OTHER = 5'd15;

    typedef struct packed {
        logic [7:0] event_status;
        logic [7:0] setup_length;
        logic [7:0] request_code;
        logic [7:0] value_low;
        logic [7:0] value_high;
    } t_req;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
        logic       last_action;
    } t_rsp;

    // One control word of the sequencer program
    typedef struct packed {
        logic [1:0] act;
        logic [1:0] src;
        logic [7:0] imm;
        logic       loop;
        logic [1:0] endc;
    } t_uword;

    // Program start handed from the dispatch logic to the sequencer
    typedef struct packed {
        logic            go;
        logic [PC_W-1:0] pc;
        logic [4:0]      len;
        logic [4:0]      base;
        logic [1:0]      sel;
    } t_start;

    // Register fields that appear inside the descriptors
    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [7:0]  max_power;
        logic [7:0]  packet_size;
    } t_desc_cfg;

    function automatic logic [4:0] f_desc_size(input logic [1:0] sel);
        logic [4:0] size;
        case (sel)
            DESC_DEVICE: size = DEVICE_SIZE;
            DESC_CONFIG: size = CONFIG_SIZE;
            default:     size = 5'd0;
        endcase
        return size;
    endfunction

    function automatic logic [7:0] f_desc_byte(input logic [1:0] sel, input logic [4:0] idx,
                                               input t_desc_cfg cfg);
        logic [7:0] b;
        b = 8'h00;
        case (sel)
            DESC_DEVICE: begin
                case (idx)
                    5'd0:    b = 8'd18;
                    5'd1:    b = 8'h01;
                    5'd3:    b = 8'h02;
                    5'd7:    b = cfg.packet_size;
                    5'd8:    b = cfg.vendor_id[7:0];
                    5'd9:    b = cfg.vendor_id[15:8];
                    5'd10:   b = cfg.product_id[7:0];
                    5'd11:   b = cfg.product_id[15:8];
                    5'd12:   b = 8'h01;
                    5'd17:   b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
            DESC_CONFIG: begin
                case (idx)
                    5'd0:    b = 8'd9;
                    5'd1:    b = 8'h02;
                    5'd2:    b = 8'd9;
                    5'd5:    b = 8'h01;
                    5'd7:    b = 8'h80;
                    5'd8:    b = cfg.max_power;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[src/usb_ep0_enumeration_responder_unit.sv]
// Top level of the USB endpoint-zero enumeration responder: configuration
// registers, request state and program dispatch. Depends on usbep0_pkg, usbep0_seq.
//
//  channel   signals                          direction  payload
//  request   i_valid / o_stall                in         i_req  (t_req)
//  result    o_valid / i_stall                out        o_rsp  (t_rsp)
//  config    i_cfg_valid / o_cfg_ready        in         i_cfg_index, i_cfg_data
//
// A request is taken while the sequencer is idle; its actions then leave at one per
// cycle from the microcode sequencer unless the result side stalls, N actions per
// request with N up to 3 + min(18, PACKET_SIZE). A request with no actions frees
// the input in the next cycle. A stall on the result side holds the sequencer step.
// Reset is synchronous; it restores the register defaults and clears request state.
module usb_ep0_enumeration_responder_unit #(
    parameter int PACKET_SIZE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  usbep0_pkg::t_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output usbep0_pkg::t_rsp  o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import usbep0_pkg::*;

    localparam logic [6:0] PKT = 7'(PACKET_SIZE);

    logic [15:0] r_vendor_id;
    logic [15:0] r_product_id;
    logic [7:0]  r_max_power;
    logic [7:0]  r_pending_request, n_pending_request;
    logic [1:0]  r_selected, n_selected;
    logic [4:0]  r_bytes_sent, n_bytes_sent;
    logic [7:0]  r_device_address, n_device_address;
    logic        w_busy;
    logic        w_accept;
    t_start      w_start;
    t_desc_cfg   w_desc_cfg;
    logic [1:0]  w_setup_sel;
    logic [4:0]  w_size;
    logic [4:0]  w_remain;

    assign o_stall = w_busy;
    assign w_accept = i_valid && !w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_desc_cfg = '{r_vendor_id, r_product_id, r_max_power, 8'(PACKET_SIZE)};

    // Decode the request and choose the program entry
    always_comb begin
        n_pending_request = r_pending_request;
        n_selected = r_selected;
        n_bytes_sent = r_bytes_sent;
        n_device_address = r_device_address;
        w_start = '{1'b0, PC_UNLOCK, 5'd0, 5'd0, r_selected};
        w_setup_sel = r_selected;
        w_size = 5'd0;
        w_remain = 5'd0;
        if (i_req.value_high == 8'd1 || i_req.value_high == 8'd2) begin
            w_setup_sel = i_req.value_high[1:0];
        end
        if (i_req.event_status == STS_SETUP) begin
            if (i_req.setup_length == SETUP_LEN) begin
                n_pending_request = i_req.request_code;
                if (i_req.request_code == REQ_GET_DESC) begin
                    w_size = f_desc_size(w_setup_sel);
                    if (w_size == 5'd0) begin
                        w_size = NULL_SIZE;
                    end
                    w_remain = ({2'b00, w_size} > PKT) ? PKT[4:0] : w_size;
                    n_selected = w_setup_sel;
                    n_bytes_sent = w_remain;
                    w_start = '{1'b1, PC_GET_DESC, w_remain, 5'd0, w_setup_sel};
                end else if (i_req.request_code == REQ_SET_ADDR) begin
                    n_device_address = i_req.value_low;
                    w_start = '{1'b1, PC_SET_ADDR, 5'd0, 5'd0, r_selected};
                end
            end
        end else if (i_req.event_status == STS_EP0_IN) begin
            w_size = f_desc_size(r_selected);
            if (r_pending_request == REQ_GET_DESC && w_size != 5'd0) begin
                w_remain = (r_bytes_sent < w_size) ? (w_size - r_bytes_sent) : 5'd0;
                if ({2'b00, w_remain} > PKT) begin
                    w_remain = PKT[4:0];
                end
                n_bytes_sent = r_bytes_sent + w_remain;
                w_start = '{1'b1, PC_IN_DESC, w_remain, r_bytes_sent, r_selected};
            end else if (r_pending_request == REQ_SET_ADDR) begin
                w_start = '{1'b1, PC_IN_ADDR, 5'd0, 5'd0, r_selected};
            end else begin
                w_start = '{1'b1, PC_UNLOCK, 5'd0, 5'd0, r_selected};
            end
        end else if (i_req.event_status == STS_EP0_OUT) begin
            w_start = '{1'b1, PC_UNLOCK, 5'd0, 5'd0, r_selected};
        end else begin
            w_start = '{1'b1, PC_OTHER, 5'd0, 5'd0, r_selected};
        end
        w_start.go = w_start.go && w_accept;
    end

    // Update request state on accept and registers on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor_id <= 16'h1234;
            r_product_id <= 16'h5678;
            r_max_power <= 8'd250;
            r_pending_request <= 8'h00;
            r_selected <= DESC_NONE;
            r_bytes_sent <= 5'd0;
            r_device_address <= 8'h00;
        end else begin
            if (w_accept) begin
                r_pending_request <= n_pending_request;
                r_selected <= n_selected;
                r_bytes_sent <= n_bytes_sent;
                r_device_address <= n_device_address;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VENDOR_ID:  r_vendor_id <= i_cfg_data;
                    CFG_PRODUCT_ID: r_product_id <= i_cfg_data;
                    CFG_MAX_POWER:  r_max_power <= i_cfg_data[7:0];
                    default:        r_max_power <= r_max_power;
                endcase
            end
        end
    end

    usbep0_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_desc_cfg (w_desc_cfg),
        .i_addr     (r_device_address),
        .o_busy     (w_busy),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp)
    );

endmodule

[src/usbep0_ucode_rom.sv]
// Microcode ROM of the endpoint-zero responder: one control word per program step.
// Depends on usbep0_pkg.
module usbep0_ucode_rom (
    input  logic [usbep0_pkg::PC_W-1:0] i_pc,
    output usbep0_pkg::t_uword          o_word
);
    import usbep0_pkg::*;

    // Programs: get descriptor, IN data, set address, IN address, unlock, other
    always_comb begin
        case (i_pc)
            5'd0:    o_word = '{ACT_CMD,  SRC_IMM,  CMD_WR_EP0,   1'b0, END_NEVER};
            5'd1:    o_word = '{ACT_DATA, SRC_LEN,  8'h00,        1'b0, END_NEVER};
            5'd2:    o_word = '{ACT_DATA, SRC_DESC, 8'h00,        1'b1, END_NEVER};
            5'd3:    o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_ALWAYS};
            5'd4:    o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_NEVER};
            5'd5:    o_word = '{ACT_CMD,  SRC_IMM,  CMD_WR_EP0,   1'b0, END_NEVER};
            5'd6:    o_word = '{ACT_DATA, SRC_LEN,  8'h00,        1'b0, END_IF_LEN0};
            5'd7:    o_word = '{ACT_DATA, SRC_DESC, 8'h00,        1'b1, END_ALWAYS};
            5'd8:    o_word = '{ACT_CMD,  SRC_IMM,  CMD_WR_EP0,   1'b0, END_NEVER};
            5'd9:    o_word = '{ACT_DATA, SRC_IMM,  8'h00,        1'b0, END_NEVER};
            5'd10:   o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_ALWAYS};
            5'd11:   o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_NEVER};
            5'd12:   o_word = '{ACT_CMD,  SRC_IMM,  CMD_SET_ADDR, 1'b0, END_NEVER};
            5'd13:   o_word = '{ACT_DATA, SRC_ADDR, 8'h00,        1'b0, END_ALWAYS};
            5'd14:   o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_ALWAYS};
            5'd15:   o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_NEVER};
            5'd16:   o_word = '{ACT_READ, SRC_IMM,  8'h00,        1'b0, END_ALWAYS};
            default: o_word = '{ACT_CMD,  SRC_IMM,  CMD_UNLOCK,   1'b0, END_ALWAYS};
        endcase
    end

endmodule

[src/usbep0_seq.sv]
// Step sequencer of the endpoint-zero responder: program counter, loop counter,
// byte datapath and the result register. Depends on usbep0_pkg and usbep0_ucode_rom.
module usbep0_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  usbep0_pkg::t_start    i_start,
    input  usbep0_pkg::t_desc_cfg i_desc_cfg,
    input  logic [7:0]            i_addr,
    output logic                  o_busy,
    output logic                  o_valid,
    input  logic                  i_stall,
    output usbep0_pkg::t_rsp      o_rsp
);
    import usbep0_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [4:0]            r_cnt, n_cnt;
    logic [4:0]            r_len, r_base;
    logic [1:0]            r_sel;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;
    t_uword                w_word;
    logic                  w_emit;
    logic                  w_loop_done;
    logic                  w_last;
    logic [7:0]            w_byte;

    usbep0_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_word (w_word)
    );

    // Emit one action when running and the result register is free or being taken
    assign w_emit = (r_state == S_RUN) && (!r_out_valid || !i_stall);
    assign w_loop_done = (r_cnt + 5'd1) == r_len;

    // Select the byte source of the current step
    always_comb begin
        case (w_word.src)
            SRC_IMM:  w_byte = w_word.imm;
            SRC_LEN:  w_byte = {3'b000, r_len};
            SRC_DESC: w_byte = f_desc_byte(r_sel, r_base + r_cnt, i_desc_cfg);
            SRC_ADDR: w_byte = i_addr;
            default:  w_byte = 8'h00;
        endcase
    end

    // End of program on this step
    always_comb begin
        case (w_word.endc)
            END_ALWAYS:  w_last = !w_word.loop || w_loop_done;
            END_IF_LEN0: w_last = (r_len == 5'd0);
            default:     w_last = 1'b0;
        endcase
    end

    // Advance the step counter, repeat loop steps, hold on a stall
    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        n_cnt = r_cnt;
        n_out = r_out;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_state = S_RUN;
                    n_pc = i_start.pc;
                    n_cnt = 5'd0;
                end
            end
            S_RUN: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_out = '{w_word.act, w_byte, w_last};
                    if (w_word.loop && !w_loop_done) begin
                        n_cnt = r_cnt + 5'd1;
                    end else begin
                        n_cnt = 5'd0;
                        n_pc = r_pc + 5'd1;
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pc <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_pc <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    // Latch the program operands at start
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_start.go && r_state == S_IDLE) begin
            r_len <= i_start.len;
            r_base <= i_start.base;
            r_sel <= i_start.sel;
        end
    end

    assign o_busy = (r_state == S_RUN);
    assign o_valid = r_out_valid;
    assign o_rsp = r_out;

endmodule
